>>> rtl/sfb_pkg.sv
`timescale 1ns / 1ps

package sfb_pkg;

  localparam logic [7:0]  FRAME_HEAD = 8'hE6;
  localparam logic [7:0]  FRAME_TAIL = 8'h6E;
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  localparam int unsigned NUM_SLOTS = 12;

  typedef logic [3:0] slot_t;

  localparam slot_t SLOT_HEAD0  = 4'd0;
  localparam slot_t SLOT_HEAD1  = 4'd1;
  localparam slot_t SLOT_SEQ_HI = 4'd2;
  localparam slot_t SLOT_SEQ_LO = 4'd3;
  localparam slot_t SLOT_CODE   = 4'd4;
  localparam slot_t SLOT_LEN_HI = 4'd5;
  localparam slot_t SLOT_LEN_LO = 4'd6;
  localparam slot_t SLOT_DATA   = 4'd7;
  localparam slot_t SLOT_CRC_HI = 4'd8;
  localparam slot_t SLOT_CRC_LO = 4'd9;
  localparam slot_t SLOT_TAIL0  = 4'd10;
  localparam slot_t SLOT_TAIL1  = 4'd11;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/serial_frame_builder_crc16_core.sv
`timescale 1ns / 1ps

// Serial frame builder with a CRC-16/MAXIM check word.
// The input channel takes one item per transfer. An item with the first flag
// opens a frame and yields the header E6 E6, sequence, message code and
// length. Inside an open frame, an item with payload yields that byte and an
// item with tlast closes the frame and yields the CRC, high byte first, then
// 6E 6E; outside a frame both are dropped. The final 6E carries out_tlast,
// and out_tuser flags a payload count that differs from the declared length.
// The output channel moves one frame byte per transfer. An accepted item is
// held in the job registers; its bytes enter the output register in order,
// one byte per cycle unless the receiver stalls. An item yields up to 12
// bytes; one that yields nothing is retired without output. The next item is
// accepted in the cycle that the current item's last byte enters the output
// register, so payload-only items run at one item per cycle unless the
// receiver stalls. The byte rate is set by the single output register and
// the one-byte CRC update per cycle. When the receiver stalls, the output
// register holds its byte and the pending item waits; in_tready stays low
// until the item's last byte can enter the output register.
// Reset clears the CRC, the counters, the open-frame flag and both
// pipeline valid flags; no frame is open after reset.

module serial_frame_builder_crc16_core
  import sfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sequence_number [15:0], message_code [23:16], payload_length [39:24],
  // data_byte [47:40]
  input  logic [47:0] in_tdata,
  // has_data [0], first_item [1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte [7:0]
  output logic [7:0]  out_tdata,
  // length_error [0]
  output logic        out_tuser,
  output logic        out_tlast
);

  logic        job_valid_r;
  logic [15:0] job_seq_r;
  logic [7:0]  job_code_r;
  logic [15:0] job_len_r;
  logic [7:0]  job_data_r;
  logic        job_has_data_r;
  logic        job_first_r;
  logic        job_last_r;
  slot_t       idx_r;
  slot_t       idx_nxt;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] bytes_r;
  logic [15:0] bytes_nxt;
  logic [15:0] decl_r;
  logic [15:0] decl_nxt;
  logic        in_frame_r;
  logic        in_frame_nxt;
  logic        overrun_r;
  logic        overrun_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;
  logic        out_err_r;

  logic                 in_frame_eff;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] pending;
  logic [NUM_SLOTS-1:0] rest;
  slot_t                slot;
  logic                 can_emit;
  logic                 emit;
  logic                 job_done;
  logic                 in_fire;
  logic [7:0]           slot_byte;
  logic                 slot_end;
  logic                 slot_err;
  logic [15:0]          crc_final;

  assign in_frame_eff = job_first_r | in_frame_r;
  assign mask = {{4{job_last_r & in_frame_eff}}, job_has_data_r & in_frame_eff,
                 {7{job_first_r}}};

  always_comb begin
    pending = '0;
    slot = SLOT_HEAD0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      pending[k] = mask[k] && (slot_t'(k) >= idx_r);
    end
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (pending[k]) begin
        slot = slot_t'(k);
      end
    end
  end

  assign rest      = pending & (pending - NUM_SLOTS'(1));
  assign can_emit  = !out_valid_r || out_tready;
  assign emit      = job_valid_r && (pending != '0) && can_emit;
  assign job_done  = job_valid_r && ((pending == '0) || (can_emit && (rest == '0)));
  assign in_tready = !job_valid_r || job_done;
  assign in_fire   = in_tvalid && in_tready;
  assign crc_final = crc_r ^ CRC_XOROUT;

  always_comb begin
    slot_byte    = FRAME_HEAD;
    slot_end     = 1'b0;
    slot_err     = 1'b0;
    crc_nxt      = crc_r;
    bytes_nxt    = bytes_r;
    decl_nxt     = decl_r;
    in_frame_nxt = in_frame_r;
    overrun_nxt  = overrun_r;
    case (slot)
      SLOT_HEAD0: begin
        slot_byte    = FRAME_HEAD;
        crc_nxt      = CRC_INIT;
        bytes_nxt    = '0;
        decl_nxt     = job_len_r;
        in_frame_nxt = 1'b1;
        overrun_nxt  = 1'b0;
      end
      SLOT_HEAD1:  slot_byte = FRAME_HEAD;
      SLOT_SEQ_HI: slot_byte = job_seq_r[15:8];
      SLOT_SEQ_LO: slot_byte = job_seq_r[7:0];
      SLOT_CODE:   slot_byte = job_code_r;
      SLOT_LEN_HI: slot_byte = job_len_r[15:8];
      SLOT_LEN_LO: slot_byte = job_len_r[7:0];
      SLOT_DATA: begin
        slot_byte = job_data_r;
        if (bytes_r == 16'hFFFF) begin
          overrun_nxt = 1'b1;
        end else begin
          bytes_nxt = bytes_r + 16'd1;
        end
      end
      SLOT_CRC_HI: slot_byte = crc_final[15:8];
      SLOT_CRC_LO: slot_byte = crc_final[7:0];
      SLOT_TAIL0:  slot_byte = FRAME_TAIL;
      SLOT_TAIL1: begin
        slot_byte    = FRAME_TAIL;
        slot_end     = 1'b1;
        slot_err     = overrun_r || (bytes_r != decl_r);
        in_frame_nxt = 1'b0;
      end
      default: slot_byte = FRAME_HEAD;
    endcase
    case (slot) inside
      SLOT_SEQ_HI, SLOT_SEQ_LO, SLOT_CODE, SLOT_LEN_HI, SLOT_LEN_LO, SLOT_DATA: begin
        crc_nxt = crc16_byte(crc_r, slot_byte);
      end
      default: ;
    endcase
  end

  assign idx_nxt = slot + slot_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= SLOT_HEAD0;
    end else if (in_fire) begin
      job_valid_r <= 1'b1;
      idx_r       <= SLOT_HEAD0;
    end else if (job_done) begin
      job_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_seq_r      <= in_tdata[15:0];
      job_code_r     <= in_tdata[23:16];
      job_len_r      <= in_tdata[39:24];
      job_data_r     <= in_tdata[47:40];
      job_has_data_r <= in_tuser[0];
      job_first_r    <= in_tuser[1];
      job_last_r     <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      bytes_r    <= '0;
      decl_r     <= '0;
      in_frame_r <= 1'b0;
      overrun_r  <= 1'b0;
    end else if (emit) begin
      crc_r      <= crc_nxt;
      bytes_r    <= bytes_nxt;
      decl_r     <= decl_nxt;
      in_frame_r <= in_frame_nxt;
      overrun_r  <= overrun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= slot_byte;
      out_end_r  <= slot_end;
      out_err_r  <= slot_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_err_r;

endmodule

>>> sim/tb_serial_frame_builder_crc16_core.sv
`timescale 1ns / 1ps

module tb_serial_frame_builder_crc16_core;
  import sfb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] value;
    logic       frame_end;
    logic       length_error;
  } frame_byte_t;

  class frame_byte_board;
    frame_byte_t expected_bytes[$];
    logic [15:0] crc_reg;
    logic [15:0] payload_count;
    logic [15:0] declared_len;
    bit          frame_open;
    bit          count_over;
    int unsigned failures;
    int unsigned bytes_checked;
    int unsigned frames_closed;
    int unsigned frames_flagged;

    function new();
      crc_reg = CRC_INIT;
      payload_count = '0;
      declared_len = '0;
      frame_open = 1'b0;
      count_over = 1'b0;
      failures = 0;
      bytes_checked = 0;
      frames_closed = 0;
      frames_flagged = 0;
    endfunction

    function void push_byte(logic [7:0] value, logic frame_end, logic length_error);
      frame_byte_t entry;
      entry.value = value;
      entry.frame_end = frame_end;
      entry.length_error = length_error;
      expected_bytes.push_back(entry);
    endfunction

    // Reflected CRC-16 update, one bit of the byte at a time from the lowest.
    function void push_crc_byte(logic [7:0] value);
      logic [15:0] acc;
      acc = crc_reg;
      for (int k = 0; k < 8; k++) begin
        if (acc[0] ^ value[k]) begin
          acc = {1'b0, acc[15:1]} ^ CRC_POLY_REFLECTED;
        end else begin
          acc = {1'b0, acc[15:1]};
        end
      end
      crc_reg = acc;
      push_byte(value, 1'b0, 1'b0);
    endfunction

    function void note_item(logic [15:0] seq, logic [7:0] code, logic [15:0] len,
                            logic [7:0] data, bit has, bit first, bit last);
      logic [15:0] crc_out;
      logic        err;
      if (first) begin
        crc_reg = CRC_INIT;
        payload_count = '0;
        count_over = 1'b0;
        declared_len = len;
        frame_open = 1'b1;
        push_byte(FRAME_HEAD, 1'b0, 1'b0);
        push_byte(FRAME_HEAD, 1'b0, 1'b0);
        push_crc_byte(seq[15:8]);
        push_crc_byte(seq[7:0]);
        push_crc_byte(code);
        push_crc_byte(len[15:8]);
        push_crc_byte(len[7:0]);
      end
      if (has && frame_open) begin
        push_crc_byte(data);
        if (payload_count == 16'hFFFF) begin
          count_over = 1'b1;
        end else begin
          payload_count = payload_count + 16'd1;
        end
      end
      if (last && frame_open) begin
        crc_out = crc_reg ^ CRC_XOROUT;
        err = count_over || (payload_count != declared_len);
        push_byte(crc_out[15:8], 1'b0, 1'b0);
        push_byte(crc_out[7:0], 1'b0, 1'b0);
        push_byte(FRAME_TAIL, 1'b0, 1'b0);
        push_byte(FRAME_TAIL, 1'b1, err);
        frame_open = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        failures++;
        $error("%s mismatch: expected %02h, actual %02h", name, want, got);
      end
    endfunction

    function void check_byte(logic [7:0] value, logic frame_end, logic length_error);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        failures++;
        $error("out_byte %02h transferred with nothing pending", value);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      compare_field("out_byte", want.value, value);
      compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, frame_end});
      compare_field("length_error", {7'd0, want.length_error}, {7'd0, length_error});
      if (want.frame_end) begin
        frames_closed++;
        if (want.length_error) begin
          frames_flagged++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  bit calm_tx;
  bit calm_rx;
  frame_byte_board board;

  serial_frame_builder_crc16_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  task automatic send_item(input logic [15:0] seq, input logic [7:0] code,
                           input logic [15:0] len, input logic [7:0] data,
                           input bit has, input bit first, input bit last);
    bit accepted;
    if (!calm_tx && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {data, len, code, seq};
    in_tuser = {first, has};
    in_tlast = last;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      accepted = (in_tready === 1'b1);
      if (!accepted) begin
        @(negedge clk);
      end
    end
    board.note_item(seq, code, len, data, has, first, last);
    @(negedge clk);
  endtask

  task automatic send_rand(input bit has, input bit first, input bit last,
                           input logic [15:0] len);
    send_item(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), len,
              8'($urandom_range(0, 255)), has, first, last);
  endtask

  task automatic send_random_frame(inout int unsigned items);
    int n;
    int mid;
    bit lead;
    bit tail;
    logic [15:0] decl;
    n = $urandom_range(0, 6);
    decl = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'(n);
    if (n <= 1 && $urandom_range(0, 2) == 0) begin
      send_rand(n == 1, 1'b1, 1'b1, decl);
      items++;
    end else begin
      lead = (n > 0) && ($urandom_range(0, 1) == 1);
      tail = (n > int'(lead)) && ($urandom_range(0, 1) == 1);
      mid = n - int'(lead) - int'(tail);
      send_rand(lead, 1'b1, 1'b0, decl);
      items++;
      repeat (mid) begin
        if ($urandom_range(0, 9) == 0) begin
          send_rand(1'b0, 1'b0, 1'b0, 16'($urandom_range(0, 65535)));
        end
        send_rand(1'b1, 1'b0, 1'b0, 16'($urandom_range(0, 65535)));
        items++;
      end
      // Now and then the frame is left open and the next header abandons it.
      if ($urandom_range(0, 7) != 0) begin
        send_rand(tail, 1'b0, 1'b1, 16'($urandom_range(0, 65535)));
        items++;
      end
    end
  endtask

  initial begin : receiver
    int unsigned hold;
    forever begin
      if (!calm_rx && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        hold = $urandom_range(1, 5);
      end else begin
        out_tready = 1'b1;
        hold = $urandom_range(1, 8);
      end
      repeat (hold) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      board.check_byte(out_tdata, out_tlast, out_tuser);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_serial_frame_builder_crc16_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned items;
    board = new();
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Payload, tail and empty items with no frame open are dropped.
    send_item(16'h1234, 8'h56, 16'h0001, 8'hAB, 1'b1, 1'b0, 1'b0);
    send_item(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b1);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0);
    // Single-item frames: header, optional byte and trailer together.
    send_item(16'hFFFF, 8'hFF, 16'h0001, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1);
    send_item(16'h8001, 8'h80, 16'h0003, 8'h01, 1'b1, 1'b1, 1'b1);
    // Zero-length frame closed by a separate item.
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0);
    send_item(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b1);
    // Frame with payload on every item, matching length.
    send_item(16'hA5A5, 8'h3C, 16'h0003, 8'h00, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h80, 1'b1, 1'b0, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h7F, 1'b1, 1'b0, 1'b1);
    // A header inside an open frame abandons it.
    send_item(16'h5A5A, 8'hC3, 16'h0005, 8'h11, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h22, 1'b1, 1'b0, 1'b0);
    send_item(16'h00FF, 8'h01, 16'h0002, 8'h33, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h44, 1'b1, 1'b0, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1);
    // Short and long against the declared length.
    send_item(16'hFF00, 8'hAA, 16'hFFFF, 8'h55, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(16'h0F0F, 8'h0F, 16'h0000, 8'hF0, 1'b1, 1'b1, 1'b0);
    send_item(16'h0000, 8'h00, 16'h0000, 8'h0F, 1'b1, 1'b0, 1'b1);

    items = 0;
    while (items < 80) begin
      if ($urandom_range(0, 5) == 0) begin
        send_rand(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_rand(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 7)));
        items++;
      end
      send_random_frame(items);
    end

    calm_tx = 1'b1;
    calm_rx = 1'b1;
    items = 0;
    while (items < 25) begin
      send_random_frame(items);
    end
    in_tvalid = 1'b0;

    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d closed frames and %0d checked bytes, %0d frames with a length error.",
             board.frames_closed, board.bytes_checked, board.frames_flagged);
    $display("Stimulus included stray items, abandoned frames and stalls on both sides.");
    if (board.failures == 0) begin
      $display("tb_serial_frame_builder_crc16_core OK");
    end else begin
      $display("tb_serial_frame_builder_crc16_core NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sfb_pkg.sv
rtl/serial_frame_builder_crc16_core.sv
sim/tb_serial_frame_builder_crc16_core.sv
